// ===== rtl/core/hit_tm_pkg.sv =====
package hit_tm_pkg;

    localparam int PCT_W = 7;
    localparam int LIMIT_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PCT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PCT = 2'd2;

    localparam logic [LIMIT_W-1:0] RADIUS_LIMIT_RST = 16'hFFFF;
    localparam logic [PCT_W-1:0] LOW_PCT_RST = 7'd60;
    localparam logic [PCT_W-1:0] HIGH_PCT_RST = 7'd90;
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // out-of-range percentages: zero counts as one, anything above full as full
    function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] p);
        if (p == '0) begin
            return 7'd1;
        end else if (p > PCT_FULL) begin
            return PCT_FULL;
        end
        return p;
    endfunction

endpackage

// ===== rtl/core/hit_tm_mem.sv =====
module hit_tm_mem #(
    parameter int DEPTH = 256,
    parameter int DATA_W = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/hit_tm_div.sv =====
module hit_tm_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 9
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    // one quotient bit a cycle, restoring
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits = trial >= {1'b0, den_reg};

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            den_next = divisor;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
            end else begin
                rem_next = trial[DEN_W-1:0];
            end
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/hit_truncated_mean.sv =====
// Truncated-mean unit for the hits of one event.
// Input channel s_*: one hit per beat (energy, radius, last-hit mark).
// Result channel m_*: one beat per event, on the hit that carries the mark.
// Config channel cfg_*: register writes, always ready; write only while idle.
// A hit inside the radius limit is inserted into a sorted energy memory by
// walking down from the top entry, one entry per cycle; s_ready stays low
// until the insertion is done. A dropped hit, or one into an empty memory,
// is handled in S_IDLE without the walk; the memory has a single read port.
// At the end of the event the two sample sizes come from a reciprocal
// multiplication of a registered product. The smallest energies are then
// read back, one per cycle, up to the larger sample size. Three serial
// divisions give the means. The result then sits in an output register;
// the next event's hits are taken while it waits, and the next result
// waits until it has been taken.
// Reset clears the hit count, the radius sum and the status flags and sets
// the config registers to their defaults; the energy memory needs no clearing.
module hit_truncated_mean #(
    parameter int MAX_HITS = 256,
    parameter int VALUE_BITS = 16,
    parameter int CNT_W = $clog2(MAX_HITS + 1)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [VALUE_BITS-1:0]          s_hit_energy,
    input  logic [VALUE_BITS-1:0]          s_hit_radius,
    input  logic                           s_last_hit,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [CNT_W-1:0]               m_kept_count,
    output logic [VALUE_BITS-1:0]          m_trunc_mean_low,
    output logic [VALUE_BITS-1:0]          m_trunc_mean_high,
    output logic [VALUE_BITS-1:0]          m_mean_radius,
    output logic                           m_event_empty,
    output logic                           m_hits_dropped,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hit_tm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hit_tm_pkg::LIMIT_W-1:0] cfg_data
);

    localparam int ADDR_W = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int SUM_W = VALUE_BITS + CNT_W;
    localparam int DV_W = (CNT_W > hit_tm_pkg::PCT_W) ? CNT_W : hit_tm_pkg::PCT_W;
    localparam int CMP_W = (VALUE_BITS > hit_tm_pkg::LIMIT_W) ? VALUE_BITS
                                                              : hit_tm_pkg::LIMIT_W;
    localparam int KN_W = CNT_W + hit_tm_pkg::PCT_W;
    localparam int RECIP_W = 21;
    localparam int RECIP_SH = 27;
    localparam int KP_W = KN_W + RECIP_W;
    // ceil(2^27 / 100): exact floor division by 100 for numerators below 2^20
    localparam logic [RECIP_W-1:0] RECIP_100 = 21'd1342178;
    localparam logic [2:0] OP_KLOW = 3'd0;
    localparam logic [2:0] OP_KHIGH = 3'd1;
    localparam logic [2:0] OP_MLOW = 3'd2;
    localparam logic [2:0] OP_MHIGH = 3'd3;
    localparam logic [2:0] OP_MRAD = 3'd4;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INS  = 6'b000010,
        S_PUT  = 6'b000100,
        S_KDIV = 6'b001000,
        S_SUM  = 6'b010000,
        S_MDIV = 6'b100000
    } state_t;
    // S_OUT folded: results load from S_MDIV or S_IDLE through pend_reg
    state_t state_reg, state_next;

    logic [hit_tm_pkg::LIMIT_W-1:0] lim_reg, lim_next;
    logic [hit_tm_pkg::PCT_W-1:0]   plo_reg, plo_next, phi_reg, phi_next;
    logic [CNT_W-1:0]      count_reg, count_next, pos_reg, pos_next, idx_reg, idx_next;
    logic [CNT_W-1:0]      kl_reg, kl_next, kh_reg, kh_next;
    logic [SUM_W-1:0]      rad_reg, rad_next, sum_reg, sum_next;
    logic [SUM_W-1:0]      slo_reg, slo_next, shi_reg, shi_next;
    logic [VALUE_BITS-1:0] e_reg, e_next, mlo_reg, mlo_next, mhi_reg, mhi_next;
    logic [VALUE_BITS-1:0] mrad_reg, mrad_next;
    logic                  ovf_reg, ovf_next, last_reg, last_next;
    logic                  pend_reg, pend_next, busy_reg, busy_next;
    logic [2:0]            op_reg, op_next;

    logic                  mv_reg, mv_next;
    logic [CNT_W-1:0]      ocnt_reg, ocnt_next;
    logic [VALUE_BITS-1:0] olo_reg, olo_next, ohi_reg, ohi_next, orad_reg, orad_next;
    logic                  oemp_reg, oemp_next, odrop_reg, odrop_next;

    logic                  wr_en, rd_en;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;
    logic [VALUE_BITS-1:0] wr_data, rd_data;
    logic                  div_start, div_done;
    logic [SUM_W-1:0]      div_num, div_q;
    logic [DV_W-1:0]       div_den;
    logic [SUM_W-1:0]      sum_add;
    logic                  accept, kept, load;
    logic [hit_tm_pkg::PCT_W-1:0] pct_sel;
    logic [KN_W-1:0]       k_num;
    logic [KP_W-1:0]       k_prod;
    logic [CNT_W-1:0]      k_scaled;

    hit_tm_mem #(.DEPTH(MAX_HITS), .DATA_W(VALUE_BITS), .ADDR_W(ADDR_W)) u_mem (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
    );

    hit_tm_div #(.NUM_W(SUM_W), .DEN_W(DV_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_num),
        .divisor(div_den), .done(div_done), .quotient(div_q)
    );

    assign s_ready = (state_reg == S_IDLE) && !pend_reg;
    assign cfg_ready = 1'b1;
    assign accept = s_valid && s_ready;
    assign kept = CMP_W'(s_hit_radius) < CMP_W'(lim_reg);
    assign load = pend_reg && (!mv_reg || m_ready);
    assign sum_add = sum_reg + SUM_W'(rd_data);

    // sample size ceil(pct * n / 100): product first, then the reciprocal scale
    assign pct_sel = hit_tm_pkg::clamp_pct((op_reg == OP_KHIGH) ? phi_reg : plo_reg);
    assign k_num = KN_W'(pct_sel) * KN_W'(count_reg) + KN_W'(99);
    assign k_prod = KP_W'(sum_reg[KN_W-1:0]) * KP_W'(RECIP_100);
    assign k_scaled = k_prod[RECIP_SH +: CNT_W];

    always_comb begin
        case (op_reg)
            OP_MLOW: begin
                div_num = slo_reg;
                div_den = DV_W'(kl_reg);
            end
            OP_MHIGH: begin
                div_num = shi_reg;
                div_den = DV_W'(kh_reg);
            end
            default: begin
                div_num = rad_reg;
                div_den = DV_W'(count_reg);
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        lim_next = lim_reg;
        plo_next = plo_reg;
        phi_next = phi_reg;
        count_next = count_reg;
        pos_next = pos_reg;
        idx_next = idx_reg;
        kl_next = kl_reg;
        kh_next = kh_reg;
        rad_next = rad_reg;
        sum_next = sum_reg;
        slo_next = slo_reg;
        shi_next = shi_reg;
        e_next = e_reg;
        mlo_next = mlo_reg;
        mhi_next = mhi_reg;
        mrad_next = mrad_reg;
        ovf_next = ovf_reg;
        last_next = last_reg;
        pend_next = pend_reg;
        busy_next = busy_reg;
        op_next = op_reg;
        mv_next = mv_reg && !m_ready;
        ocnt_next = ocnt_reg;
        olo_next = olo_reg;
        ohi_next = ohi_reg;
        orad_next = orad_reg;
        oemp_next = oemp_reg;
        odrop_next = odrop_reg;
        wr_en = 1'b0;
        wr_addr = pos_reg[ADDR_W-1:0];
        wr_data = e_reg;
        rd_en = 1'b0;
        rd_addr = ADDR_W'(pos_reg - 2'd2);
        div_start = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                hit_tm_pkg::CFG_RADIUS_LIMIT: lim_next = cfg_data;
                hit_tm_pkg::CFG_LOW_PCT: plo_next = cfg_data[hit_tm_pkg::PCT_W-1:0];
                hit_tm_pkg::CFG_HIGH_PCT: phi_next = cfg_data[hit_tm_pkg::PCT_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    e_next = s_hit_energy;
                    last_next = s_last_hit;
                    op_next = OP_KLOW;
                    if (kept && (count_reg < CNT_W'(MAX_HITS))) begin
                        rad_next = rad_reg + SUM_W'(s_hit_radius);
                        if (count_reg == '0) begin
                            wr_en = 1'b1;
                            wr_addr = '0;
                            wr_data = s_hit_energy;
                            count_next = CNT_W'(1);
                            if (s_last_hit) begin
                                state_next = S_KDIV;
                            end
                        end else begin
                            rd_en = 1'b1;
                            rd_addr = ADDR_W'(count_reg - 1'b1);
                            pos_next = count_reg;
                            state_next = S_INS;
                        end
                    end else begin
                        if (kept) begin
                            ovf_next = 1'b1;
                        end
                        if (s_last_hit) begin
                            if (count_reg == '0) begin
                                pend_next = 1'b1;
                            end else begin
                                state_next = S_KDIV;
                            end
                        end
                    end
                end
            end
            S_INS: begin
                wr_en = 1'b1;
                if (rd_data > e_reg) begin
                    // shift the larger entry up one place
                    wr_data = rd_data;
                    pos_next = pos_reg - 1'b1;
                    if (pos_reg == CNT_W'(1)) begin
                        state_next = S_PUT;
                    end else begin
                        rd_en = 1'b1;
                    end
                end else begin
                    count_next = count_reg + 1'b1;
                    state_next = last_reg ? S_KDIV : S_IDLE;
                end
            end
            S_PUT: begin
                wr_en = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = last_reg ? S_KDIV : S_IDLE;
            end
            S_KDIV: begin
                if (!busy_reg) begin
                    sum_next = SUM_W'(k_num);
                    busy_next = 1'b1;
                end else begin
                    busy_next = 1'b0;
                    op_next = op_reg + 1'b1;
                    if (op_reg == OP_KLOW) begin
                        kl_next = k_scaled;
                    end else begin
                        kh_next = k_scaled;
                        rd_en = 1'b1;
                        rd_addr = '0;
                        idx_next = '0;
                        sum_next = '0;
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM: begin
                sum_next = sum_add;
                if (idx_reg + 1'b1 == kl_reg) begin
                    slo_next = sum_add;
                end
                if (idx_reg + 1'b1 == kh_reg) begin
                    shi_next = sum_add;
                end
                // run up to the larger of the two sample sizes
                if ((idx_reg + 1'b1 >= kl_reg) && (idx_reg + 1'b1 >= kh_reg)) begin
                    state_next = S_MDIV;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = ADDR_W'(idx_reg + 1'b1);
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_MDIV: begin
                if (!busy_reg) begin
                    div_start = 1'b1;
                    busy_next = 1'b1;
                end else if (div_done) begin
                    busy_next = 1'b0;
                    op_next = op_reg + 1'b1;
                    case (op_reg)
                        OP_MLOW: mlo_next = div_q[VALUE_BITS-1:0];
                        OP_MHIGH: mhi_next = div_q[VALUE_BITS-1:0];
                        OP_MRAD: begin
                            mrad_next = div_q[VALUE_BITS-1:0];
                            pend_next = 1'b1;
                            state_next = S_IDLE;
                        end
                        default: ;
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase

        // hold the finished event until the output register is free
        if (load) begin
            mv_next = 1'b1;
            ocnt_next = count_reg;
            oemp_next = count_reg == '0;
            odrop_next = ovf_reg;
            olo_next = (count_reg == '0) ? '0 : mlo_reg;
            ohi_next = (count_reg == '0) ? '0 : mhi_reg;
            orad_next = (count_reg == '0) ? '0 : mrad_reg;
            count_next = '0;
            rad_next = '0;
            ovf_next = 1'b0;
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            lim_reg <= hit_tm_pkg::RADIUS_LIMIT_RST;
            plo_reg <= hit_tm_pkg::LOW_PCT_RST;
            phi_reg <= hit_tm_pkg::HIGH_PCT_RST;
            count_reg <= '0;
            rad_reg <= '0;
            ovf_reg <= 1'b0;
            pend_reg <= 1'b0;
            busy_reg <= 1'b0;
            op_reg <= OP_KLOW;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            lim_reg <= lim_next;
            plo_reg <= plo_next;
            phi_reg <= phi_next;
            count_reg <= count_next;
            rad_reg <= rad_next;
            ovf_reg <= ovf_next;
            pend_reg <= pend_next;
            busy_reg <= busy_next;
            op_reg <= op_next;
            mv_reg <= mv_next;
        end
        pos_reg <= pos_next;
        idx_reg <= idx_next;
        kl_reg <= kl_next;
        kh_reg <= kh_next;
        sum_reg <= sum_next;
        slo_reg <= slo_next;
        shi_reg <= shi_next;
        e_reg <= e_next;
        mlo_reg <= mlo_next;
        mhi_reg <= mhi_next;
        mrad_reg <= mrad_next;
        last_reg <= last_next;
        ocnt_reg <= ocnt_next;
        olo_reg <= olo_next;
        ohi_reg <= ohi_next;
        orad_reg <= orad_next;
        oemp_reg <= oemp_next;
        odrop_reg <= odrop_next;
    end

    assign m_valid = mv_reg;
    assign m_kept_count = ocnt_reg;
    assign m_trunc_mean_low = olo_reg;
    assign m_trunc_mean_high = ohi_reg;
    assign m_mean_radius = orad_reg;
    assign m_event_empty = oemp_reg;
    assign m_hits_dropped = odrop_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_HITS))
        else $error("kept count above capacity");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (m_event_empty == (m_kept_count == '0)))
        else $error("empty flag disagrees with kept count");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hits_dropped) |-> (m_kept_count == CNT_W'(MAX_HITS)))
        else $error("hits dropped below capacity");

    a_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SUM) |-> ((idx_reg < kl_reg) || (idx_reg < kh_reg)))
        else $error("read-back index past sample size");

endmodule

// ===== dv/hit_truncated_mean_test.sv =====
`timescale 1ns / 1ps

module hit_truncated_mean_test;

    localparam int MAX_HITS = 256;
    localparam int VALUE_BITS = 16;
    localparam int CNT_W = 9;
    localparam logic [hit_tm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 600;
    localparam int HIT_TARGET = 1050;

    typedef struct packed {
        logic [CNT_W-1:0]      kept_count;
        logic [VALUE_BITS-1:0] mean_low;
        logic [VALUE_BITS-1:0] mean_high;
        logic [VALUE_BITS-1:0] mean_radius;
        logic                  empty;
        logic                  dropped;
    } event_summary_t;

    class hit_event_tracker;
        logic [hit_tm_pkg::LIMIT_W-1:0] radius_limit;
        logic [hit_tm_pkg::PCT_W-1:0]   low_pct;
        logic [hit_tm_pkg::PCT_W-1:0]   high_pct;
        longint unsigned    energies[$];
        longint unsigned    radius_sum;
        bit                 overflow;
        event_summary_t     pending[$];
        int                 errors;

        function new();
            radius_limit = 16'hFFFF;
            low_pct = 7'd60;
            high_pct = 7'd90;
            radius_sum = 0;
            overflow = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [hit_tm_pkg::CFG_IDX_W-1:0] idx,
                                logic [hit_tm_pkg::LIMIT_W-1:0] data);
            case (idx)
                hit_tm_pkg::CFG_RADIUS_LIMIT: radius_limit = data;
                hit_tm_pkg::CFG_LOW_PCT:      low_pct = data[hit_tm_pkg::PCT_W-1:0];
                hit_tm_pkg::CFG_HIGH_PCT:     high_pct = data[hit_tm_pkg::PCT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned smallest_mean(logic [hit_tm_pkg::PCT_W-1:0] pct);
            longint unsigned p, n, k, sum;
            p = (pct == 0) ? 1 : (pct > 100) ? 100 : pct;
            n = energies.size();
            k = (p * n + 99) / 100;
            if (k > n) k = n;
            sum = 0;
            for (int i = 0; i < k; i++) sum += energies[i];
            return (k == 0) ? 0 : sum / k;
        endfunction

        function void note_hit(logic [VALUE_BITS-1:0] e, logic [VALUE_BITS-1:0] r, logic last);
            event_summary_t res;
            int pos;
            if (r < radius_limit) begin
                if (energies.size() < MAX_HITS) begin
                    pos = 0;
                    while (pos < energies.size() && energies[pos] <= e) pos++;
                    energies.insert(pos, e);
                    radius_sum += r;
                end else begin
                    overflow = 1;
                end
            end
            if (!last) return;
            res.kept_count = CNT_W'(energies.size());
            res.empty = (energies.size() == 0);
            res.mean_low = VALUE_BITS'(smallest_mean(low_pct));
            res.mean_high = VALUE_BITS'(smallest_mean(high_pct));
            res.mean_radius = res.empty ? '0 : VALUE_BITS'(radius_sum / energies.size());
            res.dropped = overflow;
            pending = {pending, res};
            energies.delete();
            radius_sum = 0;
            overflow = 0;
        endfunction

        function void check_result(event_summary_t got);
            event_summary_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat kept_count %0d", $realtime, got.kept_count);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.kept_count !== want.kept_count) begin
                $display("%0t: kept_count expected %0d actual %0d",
                         $realtime, want.kept_count, got.kept_count);
                errors++;
            end
            if (got.mean_low !== want.mean_low) begin
                $display("%0t: trunc_mean_low expected %0d actual %0d",
                         $realtime, want.mean_low, got.mean_low);
                errors++;
            end
            if (got.mean_high !== want.mean_high) begin
                $display("%0t: trunc_mean_high expected %0d actual %0d",
                         $realtime, want.mean_high, got.mean_high);
                errors++;
            end
            if (got.mean_radius !== want.mean_radius) begin
                $display("%0t: mean_radius expected %0d actual %0d",
                         $realtime, want.mean_radius, got.mean_radius);
                errors++;
            end
            if (got.empty !== want.empty) begin
                $display("%0t: event_empty expected %0d actual %0d",
                         $realtime, want.empty, got.empty);
                errors++;
            end
            if (got.dropped !== want.dropped) begin
                $display("%0t: hits_dropped expected %0d actual %0d",
                         $realtime, want.dropped, got.dropped);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [VALUE_BITS-1:0] s_hit_energy = '0;
    logic [VALUE_BITS-1:0] s_hit_radius = '0;
    logic s_last_hit = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [CNT_W-1:0] m_kept_count;
    logic [VALUE_BITS-1:0] m_trunc_mean_low;
    logic [VALUE_BITS-1:0] m_trunc_mean_high;
    logic [VALUE_BITS-1:0] m_mean_radius;
    logic m_event_empty;
    logic m_hits_dropped;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [hit_tm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [hit_tm_pkg::LIMIT_W-1:0] cfg_data = '0;

    hit_truncated_mean #(.MAX_HITS(MAX_HITS), .VALUE_BITS(VALUE_BITS)) DUT (.*);

    hit_event_tracker tracker = new();
    int burst_left = 0;
    int hits_sent = 0;
    int idle_cycles = 0;
    int stall_mode = 0;
    int stall_left = 0;

    always #10 aclk = ~aclk;

    // receiver back-pressure: switch between open, random and mostly-stalled
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_left <= $urandom_range(16, 128);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                tracker.check_result({m_kept_count, m_trunc_mean_low, m_trunc_mean_high,
                                      m_mean_radius, m_event_empty, m_hits_dropped});
            if (s_valid && s_ready)
                tracker.note_hit(s_hit_energy, s_hit_radius, s_last_hit);
            if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("hit_truncated_mean verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_hit(logic [VALUE_BITS-1:0] e, logic [VALUE_BITS-1:0] r, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_valid <= 1'b1;
        s_hit_energy <= e;
        s_hit_radius <= r;
        s_last_hit <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        hits_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending.size() != 0) @(posedge aclk);
        // a hit that gave no result may still be sorting in
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [hit_tm_pkg::CFG_IDX_W-1:0] idx,
                             logic [hit_tm_pkg::LIMIT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.write_reg(idx, data);
    endtask

    task automatic configure(logic [hit_tm_pkg::LIMIT_W-1:0] lim,
                             logic [hit_tm_pkg::LIMIT_W-1:0] lo,
                             logic [hit_tm_pkg::LIMIT_W-1:0] hi);
        drain();
        write_reg(hit_tm_pkg::CFG_RADIUS_LIMIT, lim);
        write_reg(hit_tm_pkg::CFG_LOW_PCT, lo);
        write_reg(hit_tm_pkg::CFG_HIGH_PCT, hi);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_radius(bit inside_cut);
        if (inside_cut && tracker.radius_limit > 0)
            return VALUE_BITS'($urandom_range(0, tracker.radius_limit - 1));
        return VALUE_BITS'($urandom());
    endfunction

    task automatic random_event(int n);
        logic [VALUE_BITS-1:0] e;
        logic [VALUE_BITS-1:0] base;
        base = VALUE_BITS'($urandom());
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: e = base;                       // clusters of equal energies
                1: e = base + VALUE_BITS'($urandom_range(0, 3));
                default: e = VALUE_BITS'($urandom());
            endcase
            send_hit(e, pick_radius($urandom_range(0, 4) != 0), i == n - 1);
        end
    endtask

    initial begin
        int phase;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: single extreme hits, a discarded-only event, equal energies
        send_hit(16'h0000, 16'h0000, 1);
        send_hit(16'hFFFF, 16'hFFFE, 1);
        send_hit(16'h1234, 16'hFFFF, 1);
        send_hit(16'h0100, 16'h0010, 0);
        send_hit(16'h0100, 16'h0020, 0);
        send_hit(16'h0100, 16'h0030, 0);
        send_hit(16'hFFFF, 16'hFFFF, 0);
        send_hit(16'h0001, 16'h4000, 1);

        // zero limit keeps nothing; fraction zero and above full
        configure(16'h0000, 16'h0000, 16'h007F);
        send_hit(16'h5555, 16'h0000, 0);
        send_hit(16'hAAAA, 16'h0000, 1);

        configure(16'd1000, 16'hFF81, 16'd100);
        write_reg(CFG_SPARE, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_hit(16'hAAAA, 16'd999, 0);
        send_hit(16'h5555, 16'd1000, 0);
        send_hit(16'h0F0F, 16'd0, 0);
        send_hit(16'hF0F0, 16'd500, 0);
        send_hit(16'h8000, 16'd250, 0);
        send_hit(16'h7FFF, 16'd1, 1);

        configure(16'hFFFF, 16'd100, 16'd0);
        send_hit(16'hFFFF, 16'hFFFE, 0);
        send_hit(16'hFFFF, 16'hFFFE, 1);

        phase = 0;
        while (hits_sent < HIT_TARGET) begin
            case (phase % 4)
                0: configure(hit_tm_pkg::LIMIT_W'($urandom()),
                             hit_tm_pkg::LIMIT_W'($urandom_range(0, 127)),
                             hit_tm_pkg::LIMIT_W'($urandom_range(0, 127)));
                1: configure(16'hFFFF, hit_tm_pkg::LIMIT_W'($urandom_range(1, 100)),
                             hit_tm_pkg::LIMIT_W'($urandom_range(1, 100)));
                2: configure($urandom_range(0, 3) == 0 ? 16'h0000 :
                             hit_tm_pkg::LIMIT_W'($urandom_range(1, 64)),
                             16'd1, 16'd100);
                default: configure(hit_tm_pkg::LIMIT_W'($urandom()),
                                   {9'($urandom_range(0, 511)), 7'(60)},
                                   {9'($urandom_range(0, 511)), 7'(90)});
            endcase
            // capacity runs: one exactly full, one past full
            if (phase == 1) begin
                random_event(MAX_HITS);
                random_event($urandom_range(MAX_HITS + 1, MAX_HITS + 6));
            end
            for (int j = $urandom_range(6, 14); j > 0 && hits_sent < HIT_TARGET; j--)
                random_event($urandom_range(0, 5) == 0 ? $urandom_range(17, 40) :
                                                         $urandom_range(1, 16));
            phase++;
        end

        drain();
        if (tracker.errors == 0) begin
            $display("hit_truncated_mean verification clean");
        end else begin
            $display("hit_truncated_mean verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/hit_tm_pkg.sv
rtl/core/hit_tm_mem.sv
rtl/core/hit_tm_div.sv
rtl/core/hit_truncated_mean.sv
dv/hit_truncated_mean_test.sv
